// ===== hw/rtl/fcp_pkg.sv =====
// ----------------------------------------------------------------------------
// fcp_pkg
// Types and constants shared by the frame cadence pacer.
// ----------------------------------------------------------------------------
package fcp_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    STEP_SEQ,
    STEP_MOD,
    STEP_PTS,
    STEP_NXT
  } step_t;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [7:0] REG_NUM   = 8'd0;
  localparam logic [7:0] REG_DENOM = 8'd1;
  localparam logic [7:0] REG_COUNT = 8'd2;
  localparam logic [7:0] REG_LOOP  = 8'd3;

  localparam logic [29:0] NSEC_PER_SEC = 30'd1000000000;

  localparam logic [6:0] MUL_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST = 7'd127;

endpackage

// ===== hw/rtl/frame_cadence_pacer_unit.sv =====
// ----------------------------------------------------------------------------
// frame_cadence_pacer_unit
// Frame pacer: due sequence, frame index and timestamp from a ns clock.
// ----------------------------------------------------------------------------
// Start, stop and polls that emit nothing go to the done state, which registers
// the result once the output is free, then return to idle. An emitting poll
// runs a bit-serial shift-add multiplier and a restoring divider on one 128-bit
// work register: sequence (multiply, divide), modulo in loop mode (divide),
// pts and next due (multiply, divide each); it ends after sequence with no frame.
// One item is in work at a time. Synchronous reset clears control state.
module frame_cadence_pacer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [63:0] now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        due,
  output logic [63:0] sequence_res,
  output logic [31:0] frame_index,
  output logic [63:0] pts,
  output logic        discontinuity,
  output logic        finished,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fcp_pkg::*;

  state_t state, state_next;
  step_t  step;

  logic [31:0] rate_num, rate_denom, frame_total;
  logic        loop_enable;

  logic        running, ended;
  logic [63:0] epoch_time, next_seq, next_due_time;
  logic [31:0] cap_num;
  logic [63:0] dvs;

  logic [127:0] work;
  logic [63:0]  mcand, rem, divisor, sel;
  logic [6:0]   cnt;

  logic        res_due, res_disc;
  logic [63:0] res_seq, res_pts;
  logic [31:0] res_frame;

  logic        in_fire, poll_go, out_free, div_end, mul_end;
  logic [64:0] mul_sum;
  logic [63:0] rsh, rnew;
  logic        ge;
  logic [127:0] work_div;
  logic [63:0] pick0, pick1, pick, cnt64;
  logic        stop_now, mod_needed, end_after;
  logic [61:0] dvs_calc;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign poll_go  = (op == OP_POLL) && running && !ended && (now >= next_due_time);
  assign mul_end  = (state == S_MUL) && (cnt == MUL_LAST);
  assign div_end  = (state == S_DIV) && (cnt == DIV_LAST);
  assign dvs_calc = {32'd0, NSEC_PER_SEC} * {30'd0, rate_denom};

  // multiplier: add on the multiplier's low bit, shift right
  assign mul_sum = {1'b0, work[127:64]} + (work[0] ? {1'b0, mcand} : 65'd0);

  // divider: one restoring step
  always_comb begin
    rsh      = {rem[62:0], work[127]};
    ge       = rem[63] || (rsh >= divisor);
    rnew     = ge ? (rsh - divisor) : rsh;
    work_div = {work[126:0], ge};
  end

  // sequence pick at the end of the first division
  always_comb begin
    cnt64    = {32'd0, frame_total};
    pick0    = (work_div[127:64] != 64'd0) ? {64{1'b1}} : work_div[63:0];
    pick1    = (pick0 < next_seq) ? next_seq : pick0;
    stop_now = 1'b0;
    pick     = pick1;
    if (!loop_enable && pick1 >= cnt64) begin
      if (next_seq >= cnt64) stop_now = 1'b1;
      else pick = cnt64 - 64'd1;
    end
    mod_needed = loop_enable && (frame_total != 32'd0);
    end_after  = !loop_enable && (next_seq >= cnt64);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_fire) state_next = poll_go ? S_MUL : S_DONE;
      S_MUL:  if (mul_end) state_next = S_DIV;
      S_DIV: begin
        if (div_end) begin
          case (step)
            STEP_SEQ: state_next = stop_now ? S_DONE : (mod_needed ? S_DIV : S_MUL);
            STEP_MOD: state_next = S_MUL;
            STEP_PTS: state_next = end_after ? S_DONE : S_MUL;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step          <= STEP_SEQ;
      rate_num      <= 32'd30;
      rate_denom    <= 32'd1;
      frame_total   <= 32'd1;
      loop_enable   <= 1'b1;
      running       <= 1'b0;
      ended         <= 1'b0;
      epoch_time    <= 64'd0;
      next_seq      <= 64'd0;
      next_due_time <= 64'd0;
      cap_num       <= 32'd0;
      dvs           <= 64'd0;
      cnt           <= 7'd0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM:   rate_num    <= cfg_data;
          REG_DENOM: rate_denom  <= cfg_data;
          REG_COUNT: frame_total <= cfg_data;
          REG_LOOP:  loop_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_due   <= 1'b0;
            res_seq   <= 64'd0;
            res_frame <= 32'd0;
            res_pts   <= 64'd0;
            res_disc  <= 1'b0;
            case (op)
              OP_START: begin
                if (!running) begin
                  cap_num       <= rate_num;
                  dvs           <= {2'b00, dvs_calc};
                  epoch_time    <= now;
                  next_seq      <= 64'd0;
                  next_due_time <= now;
                  ended         <= 1'b0;
                  running       <= 1'b1;
                end
              end
              OP_STOP: running <= 1'b0;
              default: ;
            endcase
            if (poll_go) begin
              step  <= STEP_SEQ;
              mcand <= now - epoch_time;
              work  <= {96'd0, cap_num};
              cnt   <= 7'd0;
            end
          end
        end
        S_MUL: begin
          work <= {mul_sum, work[63:1]};
          if (mul_end) begin
            cnt     <= 7'd0;
            rem     <= 64'd0;
            divisor <= (step == STEP_SEQ) ? dvs : {32'd0, cap_num};
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_DIV: begin
          if (!div_end) begin
            work <= work_div;
            rem  <= rnew;
            cnt  <= cnt + 7'd1;
          end else begin
            cnt <= 7'd0;
            rem <= 64'd0;
            case (step)
              STEP_SEQ: begin
                if (stop_now) begin
                  ended <= 1'b1;
                end else begin
                  sel       <= pick;
                  res_due   <= 1'b1;
                  res_seq   <= pick;
                  res_disc  <= (pick == 64'd0) || (pick > next_seq);
                  res_frame <= loop_enable ? 32'd0 : pick[31:0];
                  next_seq  <= pick + 64'd1;
                  work      <= {64'd0, pick};
                  mcand     <= dvs;
                  divisor   <= cnt64;
                  step      <= mod_needed ? STEP_MOD : STEP_PTS;
                end
              end
              STEP_MOD: begin
                res_frame <= rnew[31:0];
                work      <= {64'd0, sel};
                mcand     <= dvs;
                step      <= STEP_PTS;
              end
              STEP_PTS: begin
                res_pts <= epoch_time + work_div[63:0];
                if (end_after) begin
                  ended         <= 1'b1;
                  next_due_time <= {64{1'b1}};
                end else begin
                  work  <= {64'd0, next_seq};
                  mcand <= dvs;
                  step  <= STEP_NXT;
                end
              end
              default: next_due_time <= epoch_time + work_div[63:0];
            endcase
          end
        end
        S_DONE: begin
          if (out_free) begin
            due           <= res_due;
            sequence_res  <= res_seq;
            frame_index   <= res_frame;
            pts           <= res_pts;
            discontinuity <= res_disc;
            finished      <= ended;
          end
        end
        default: ;
      endcase
    end
  end

  a_stop_halts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && op == OP_STOP) |=> !running)
    else $error("stop transfer did not halt the pacer");

  a_mod_loop_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == STEP_MOD) |-> (loop_enable && frame_total != 32'd0))
    else $error("modulo pass outside loop mode");

  a_quiet_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !due) |-> (sequence_res == 64'd0 && pts == 64'd0 && !discontinuity))
    else $error("result without a frame carries data");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DIV) |-> !in_ready)
    else $error("input taken while arithmetic is running");

endmodule
